// File: hdl/assert_macros.svh
// Assertion macros shared by the RTL of the shading unit.
// Define ASSERT_OFF to compile every check away.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
// Implication checked on every rising edge outside reset.
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// Same check with no reset term, so it is also checked during reset.
`define ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define ASSERT_CLK(label, clk, rst_n, prop, msg)
`define ASSERT_ALWAYS(label, clk, prop, msg)
`endif
`endif

// File: hdl/lds_pkg.sv
// Types and constants of the Lambertian diffuse shading pipeline.
// No dependencies.
`timescale 1ns / 1ps
package lds_pkg;

    localparam int LDS_SQ_STAGES = 16;    // two root bits per stage, 64-bit radicand
    localparam int LDS_DV_STAGES = 9;     // two quotient bits per stage
    localparam int LDS_Q_W       = 18;    // cosine quotient, Q2.14 with headroom
    localparam int LDS_STAGES    = 5 + LDS_SQ_STAGES + LDS_DV_STAGES + 2;
    localparam int LDS_NORM_MSB  = 29;
    localparam int LDS_COL_SHIFT = 22;
    localparam logic [28:0] LDS_COL_HALF = 29'd1 << 21;
    localparam logic [15:0] LDS_COL_MAX  = 16'hFFFF;

    typedef struct packed {
        logic [2:0][31:0] pc;    // light times surface colour per channel
        logic [46:0]      dot;   // positive dot product, valid when pos
        logic             pos;
    } t_carry;

    typedef struct packed {
        logic [63:0] x;
        logic [35:0] rem;
        logic [31:0] root;
        t_carry      c;
    } t_sq;

    typedef struct packed {
        logic [47:0]        rem;
        logic [31:0]        len;
        logic [LDS_Q_W-1:0] q;
        t_carry             c;
    } t_dv;

endpackage

// File: hdl/lambert_diffuse_shade_unit.sv
// Lambertian diffuse shading pipeline: takes one light/hit pair per cycle while not stalled and
// delivers light colour times surface colour times the cosine between the surface normal and
// the normalised hit-to-light vector, rounded and saturated to Q8.8, or black with facing low.
// One transfer per cycle while the output is not stalled; a 16-stage square root and a 9-stage
// divider lie between the dot product and the colour multiply. Uses lds_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module lambert_diffuse_shade_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [31:0] i_light_x,
    input  logic [31:0] i_light_y,
    input  logic [31:0] i_light_z,
    input  logic [31:0] i_hit_x,
    input  logic [31:0] i_hit_y,
    input  logic [31:0] i_hit_z,
    input  logic [15:0] i_normal_x,
    input  logic [15:0] i_normal_y,
    input  logic [15:0] i_normal_z,
    input  logic [47:0] i_light_color,
    input  logic [47:0] i_surface_color,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [15:0] o_out_red,
    output logic [15:0] o_out_green,
    output logic [15:0] o_out_blue,
    output logic        o_facing
);
    import lds_pkg::*;

    function automatic t_sq sq_step(input t_sq s);
        t_sq         o;
        logic [35:0] r1;
        logic [35:0] tr;
        o  = s;
        r1 = {s.rem[33:0], s.x[63:62]};
        tr = {2'b00, s.root, 2'b01};
        if (r1 >= tr) begin
            o.rem  = r1 - tr;
            o.root = {s.root[30:0], 1'b1};
        end else begin
            o.rem  = r1;
            o.root = {s.root[30:0], 1'b0};
        end
        o.x = {s.x[61:0], 2'b00};
        return o;
    endfunction

    function automatic t_dv dv_step(input t_dv s, input int b);
        t_dv         o;
        logic [49:0] sh;
        o  = s;
        sh = {18'd0, s.len} << b;
        if ({2'b00, s.rem} >= sh) begin
            o.rem = s.rem - sh[47:0];
            o.q   = s.q | (LDS_Q_W'(1) << b);
        end
        return o;
    endfunction

    logic [LDS_STAGES-1:0] r_vld;
    logic                  w_adv;

    // Stage 1: differences, signs, magnitudes, colour products
    logic [2:0]        r1_neg;
    logic [2:0][32:0]  r1_mag;
    logic [2:0][15:0]  r1_nrm;
    logic [2:0][31:0]  r1_pc;
    // Stage 2: leading-one position of the largest magnitude
    logic [2:0]        r2_neg;
    logic [2:0][32:0]  r2_mag;
    logic [2:0][15:0]  r2_nrm;
    logic [2:0][31:0]  r2_pc;
    logic [4:0]        r2_sl;
    logic [1:0]        r2_sr;
    logic              r2_zero;
    // Stage 3: scaled magnitudes
    logic [2:0]        r3_neg;
    logic [2:0][29:0]  r3_m;
    logic [2:0][15:0]  r3_nrm;
    logic [2:0][31:0]  r3_pc;
    logic              r3_zero;
    // Stage 4: squares and normal products
    logic [2:0]        r4_neg;
    logic [2:0][59:0]  r4_sq;
    logic [2:0][46:0]  r4_t;
    logic [2:0][31:0]  r4_pc;
    logic              r4_zero;

    t_sq  r_sq [0:LDS_SQ_STAGES];
    t_dv  r_dv [1:LDS_DV_STAGES];
    logic [2:0][49:0]        r_p;
    logic                    r_q_nz;
    logic [15:0]             r_out_red;
    logic [15:0]             r_out_green;
    logic [15:0]             r_out_blue;
    logic                    r_facing;

    logic [LDS_STAGES-1:0]   n_vld;
    logic [2:0][32:0]        w_d;
    logic [32:0]             w_or;
    logic [5:0]              w_lead;
    logic [2:0][32:0]        w_sh;
    logic [61:0]             w_len2;
    logic signed [47:0]      w_dot;
    logic [2:0][28:0]        w_rnd;

    assign w_adv   = !r_vld[LDS_STAGES-1] || !i_stall;
    assign o_stall = !w_adv;
    assign n_vld   = {r_vld[LDS_STAGES-2:0], i_valid};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_adv) begin
            r_vld <= n_vld;
        end
    end

    always_comb begin
        w_d[0] = {i_light_x[31], i_light_x} - {i_hit_x[31], i_hit_x};
        w_d[1] = {i_light_y[31], i_light_y} - {i_hit_y[31], i_hit_y};
        w_d[2] = {i_light_z[31], i_light_z} - {i_hit_z[31], i_hit_z};
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            for (int i = 0; i < 3; i++) begin
                r1_neg[i] <= w_d[i][32];
                r1_mag[i] <= w_d[i][32] ? (33'd0 - w_d[i]) : w_d[i];
            end
            r1_nrm <= {i_normal_z, i_normal_y, i_normal_x};
            r1_pc[0] <= i_light_color[47:32] * i_surface_color[47:32];
            r1_pc[1] <= i_light_color[31:16] * i_surface_color[31:16];
            r1_pc[2] <= i_light_color[15:0]  * i_surface_color[15:0];
        end
    end

    // The leading one of the OR of the magnitudes is that of the largest one
    always_comb begin
        w_or   = r1_mag[0] | r1_mag[1] | r1_mag[2];
        w_lead = '0;
        for (int b = 0; b < 33; b++) begin
            if (w_or[b]) begin
                w_lead = 6'(b);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r2_neg  <= r1_neg;
            r2_mag  <= r1_mag;
            r2_nrm  <= r1_nrm;
            r2_pc   <= r1_pc;
            r2_zero <= (w_or == '0);
            if (w_lead < 6'(LDS_NORM_MSB)) begin
                r2_sl <= 5'(6'(LDS_NORM_MSB) - w_lead);
                r2_sr <= '0;
            end else begin
                r2_sl <= '0;
                r2_sr <= 2'(w_lead - 6'(LDS_NORM_MSB));
            end
        end
    end

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            w_sh[i] = (r2_sr != '0) ? (r2_mag[i] >> r2_sr) : (r2_mag[i] << r2_sl);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r3_neg  <= r2_neg;
            r3_nrm  <= r2_nrm;
            r3_pc   <= r2_pc;
            r3_zero <= r2_zero;
            for (int i = 0; i < 3; i++) begin
                r3_m[i] <= w_sh[i][29:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r4_neg  <= r3_neg;
            r4_pc   <= r3_pc;
            r4_zero <= r3_zero;
            for (int i = 0; i < 3; i++) begin
                r4_sq[i] <= r3_m[i] * r3_m[i];
                r4_t[i]  <= 47'($signed({1'b0, r3_m[i]}) * $signed(r3_nrm[i]));
            end
        end
    end

    always_comb begin
        w_len2 = {2'b00, r4_sq[0]} + {2'b00, r4_sq[1]} + {2'b00, r4_sq[2]};
        w_dot  = '0;
        for (int i = 0; i < 3; i++) begin
            if (r4_neg[i]) begin
                w_dot = w_dot - $signed({r4_t[i][46], r4_t[i]});
            end else begin
                w_dot = w_dot + $signed({r4_t[i][46], r4_t[i]});
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_sq[0].x     <= {2'b00, w_len2};
            r_sq[0].rem   <= '0;
            r_sq[0].root  <= '0;
            r_sq[0].c.pc  <= r4_pc;
            r_sq[0].c.dot <= w_dot[46:0];
            r_sq[0].c.pos <= !r4_zero && !w_dot[47] && (w_dot != '0);
        end
    end

    // Square root, two result bits per stage
    for (genvar k = 1; k <= LDS_SQ_STAGES; k++) begin : g_sq
        always_ff @(posedge i_clk) begin
            if (w_adv) begin
                r_sq[k] <= sq_step(sq_step(r_sq[k-1]));
            end
        end
    end

    // Restoring divide, dot over length; a back-facing or zero-length item divides
    // zero by all ones so that its quotient stays zero
    for (genvar k = 1; k <= LDS_DV_STAGES; k++) begin : g_dv
        localparam int B = LDS_Q_W - 1 - 2 * (k - 1);
        t_dv w_src;
        always_comb begin
            if (k == 1) begin
                w_src.rem = r_sq[LDS_SQ_STAGES].c.pos ? {1'b0, r_sq[LDS_SQ_STAGES].c.dot} : '0;
                w_src.len = r_sq[LDS_SQ_STAGES].c.pos ? r_sq[LDS_SQ_STAGES].root : '1;
                w_src.q   = '0;
                w_src.c   = r_sq[LDS_SQ_STAGES].c;
            end else begin
                w_src = r_dv[(k > 1) ? k - 1 : 1];
            end
        end
        always_ff @(posedge i_clk) begin
            if (w_adv) begin
                r_dv[k] <= dv_step(dv_step(w_src, B), B - 1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            for (int i = 0; i < 3; i++) begin
                r_p[i] <= r_dv[LDS_DV_STAGES].c.pc[i] * r_dv[LDS_DV_STAGES].q;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_q_nz <= (r_dv[LDS_DV_STAGES].q != '0);
        end
    end

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            w_rnd[i] = 29'((r_p[i] + {21'd0, LDS_COL_HALF}) >> LDS_COL_SHIFT);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_out_red   <= (w_rnd[0] > {13'd0, LDS_COL_MAX}) ? LDS_COL_MAX : w_rnd[0][15:0];
            r_out_green <= (w_rnd[1] > {13'd0, LDS_COL_MAX}) ? LDS_COL_MAX : w_rnd[1][15:0];
            r_out_blue  <= (w_rnd[2] > {13'd0, LDS_COL_MAX}) ? LDS_COL_MAX : w_rnd[2][15:0];
            // hold facing low when the quotient came out zero
            r_facing    <= r_q_nz;
        end
    end

    assign o_valid     = r_vld[LDS_STAGES-1];
    assign o_out_red   = r_out_red;
    assign o_out_green = r_out_green;
    assign o_out_blue  = r_out_blue;
    assign o_facing    = r_facing;

    `ASSERT_CLK(a_stall_needs_valid, i_clk, i_rst_n, o_stall |-> o_valid, "stall without result")
    `ASSERT_CLK(a_hold_on_stall, i_clk, i_rst_n, o_stall |=> $stable(r_vld), "pipeline moved on stall")
    `ASSERT_CLK(a_black_when_away, i_clk, i_rst_n,
        o_valid && !o_facing |-> (o_out_red == '0) && (o_out_green == '0) && (o_out_blue == '0),
        "colour on a non-facing result")
    `ASSERT_CLK(a_root_range, i_clk, i_rst_n,
        r_vld[4 + LDS_SQ_STAGES] && r_sq[LDS_SQ_STAGES].c.pos
            |-> r_sq[LDS_SQ_STAGES].root[31:29] != '0,
        "vector length below normalised range")

endmodule

// File: bench/lambert_diffuse_shade_unit_test.sv
// Self-checking bench for the Lambertian diffuse shading pipeline.
// Holds a cosine-shading predictor, a small result scoreboard class and the drivers.
// Depends only on lambert_diffuse_shade_unit and its package.
`timescale 1ns / 1ps
module lambert_diffuse_shade_unit_test;

    typedef struct {
        logic [15:0] red;
        logic [15:0] green;
        logic [15:0] blue;
        logic        facing;
    } shade_t;

    typedef struct {
        logic [31:0] lx, ly, lz, hx, hy, hz;
        logic [15:0] nx, ny, nz;
        logic [47:0] lc, sc;
    } ray_t;

    int errors = 0;

    task automatic report(input string what, input logic [15:0] got, input logic [15:0] want);
        errors++;
        $display("mismatch %s: got %0d want %0d at %0t", what, got, want, $realtime);
    endtask

    function automatic logic [63:0] root_floor(input logic [63:0] x);
        logic [63:0] res, b;
        res = 0;
        b = 64'd1 << 62;
        while (b > x) b >>= 2;
        while (b != 0) begin
            if (x >= res + b) begin
                x -= res + b;
                res = (res >> 1) + b;
            end else begin
                res >>= 1;
            end
            b >>= 2;
        end
        return res;
    endfunction

    function automatic logic [15:0] shade_chan(input logic [15:0] cl, input logic [15:0] cs,
                                               input logic [63:0] cq);
        logic [63:0] p;
        p = (64'(cl) * 64'(cs)) * cq;
        p = (p + (64'd1 << 21)) >> 22;
        return (p > 64'hFFFF) ? 16'hFFFF : p[15:0];
    endfunction

    function automatic shade_t diffuse_shade(input ray_t r);
        shade_t s;
        logic signed [63:0] d [3];
        logic signed [63:0] n [3];
        logic [63:0] mag [3];
        logic [63:0] maxm, len2, len, cq;
        logic signed [63:0] dot, t;
        s = '{16'd0, 16'd0, 16'd0, 1'b0};
        d[0] = 64'($signed(r.lx)) - 64'($signed(r.hx));
        d[1] = 64'($signed(r.ly)) - 64'($signed(r.hy));
        d[2] = 64'($signed(r.lz)) - 64'($signed(r.hz));
        n[0] = 64'($signed(r.nx));
        n[1] = 64'($signed(r.ny));
        n[2] = 64'($signed(r.nz));
        maxm = 0;
        for (int i = 0; i < 3; i++) begin
            mag[i] = d[i] < 0 ? -d[i] : d[i];
            if (mag[i] > maxm) maxm = mag[i];
        end
        if (maxm == 0) return s;
        while (maxm >= (64'd1 << 30)) begin
            maxm >>= 1;
            for (int i = 0; i < 3; i++) mag[i] >>= 1;
        end
        while (maxm < (64'd1 << 29)) begin
            maxm <<= 1;
            for (int i = 0; i < 3; i++) mag[i] <<= 1;
        end
        len2 = 0;
        dot = 0;
        for (int i = 0; i < 3; i++) begin
            t = $signed(mag[i]) * n[i];
            len2 += mag[i] * mag[i];
            dot += (d[i] < 0) ? -t : t;
        end
        if (dot <= 0) return s;
        len = root_floor(len2);
        if (len == 0) return s;
        cq = 64'(dot) / len;
        if (cq == 0) return s;
        s.red = shade_chan(r.lc[47:32], r.sc[47:32], cq);
        s.green = shade_chan(r.lc[31:16], r.sc[31:16], cq);
        s.blue = shade_chan(r.lc[15:0], r.sc[15:0], cq);
        s.facing = 1'b1;
        return s;
    endfunction

    class shade_board;
        shade_t pending[$];

        function void note_ray(input ray_t r);
            pending.push_back(diffuse_shade(r));
        endfunction

        task check_shade(input shade_t got);
            shade_t w;
            if (pending.size() == 0) begin
                report("unexpected result", got.red, 16'd0);
                return;
            end
            w = pending.pop_front();
            if (got.red !== w.red) report("red", got.red, w.red);
            if (got.green !== w.green) report("green", got.green, w.green);
            if (got.blue !== w.blue) report("blue", got.blue, w.blue);
            if (got.facing !== w.facing) report("facing", got.facing, w.facing);
        endtask
    endclass

    logic i_clk = 0, i_rst_n = 0, i_valid = 0, i_stall = 1;
    logic o_stall, o_valid, o_facing;
    logic [31:0] i_light_x = 0, i_light_y = 0, i_light_z = 0;
    logic [31:0] i_hit_x = 0, i_hit_y = 0, i_hit_z = 0;
    logic [15:0] i_normal_x = 0, i_normal_y = 0, i_normal_z = 0;
    logic [47:0] i_light_color = 0, i_surface_color = 0;
    logic [15:0] o_out_red, o_out_green, o_out_blue;

    lambert_diffuse_shade_unit u_dut (.*);

    shade_board board = new();
    int idle_cycles = 0;
    bit sending_done = 0;
    bit hold_long = 0;

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            shade_t g;
            g.red = o_out_red;
            g.green = o_out_green;
            g.blue = o_out_blue;
            g.facing = o_facing;
            board.check_shade(g);
        end
    end

    // watchdog: count cycles with no transfer on either side
    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles > 2000) begin
            $display("FAIL lambert_diffuse_shade_unit");
            $finish;
        end
    end

    // receiver: random stall per result, long hold-off on request
    initial begin
        int gap;
        @(posedge i_clk iff i_rst_n);
        forever begin
            if (hold_long) begin
                i_stall <= 1;
                repeat (120) @(posedge i_clk);
                hold_long = 0;
            end
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 7);
            if (gap > 0) begin
                i_stall <= 1;
                repeat (gap) @(posedge i_clk);
            end
            i_stall <= 0;
            @(posedge i_clk iff o_valid);
        end
    end

    task automatic send_ray(input ray_t r, input int gap);
        if (gap > 0) begin
            i_valid <= 0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid <= 1;
        {i_light_x, i_light_y, i_light_z} <= {r.lx, r.ly, r.lz};
        {i_hit_x, i_hit_y, i_hit_z} <= {r.hx, r.hy, r.hz};
        {i_normal_x, i_normal_y, i_normal_z} <= {r.nx, r.ny, r.nz};
        i_light_color <= r.lc;
        i_surface_color <= r.sc;
        @(posedge i_clk iff !o_stall);
        board.note_ray(r);
    endtask

    function automatic logic [15:0] unit_comp();
        int m;
        m = $urandom_range(0, 16384);
        return $urandom_range(0, 1) ? 16'(-m) : 16'(m);
    endfunction

    function automatic ray_t random_ray();
        ray_t r;
        int mode;
        mode = $urandom_range(0, 9);
        r.lx = $urandom; r.ly = $urandom; r.lz = $urandom;
        if (mode < 6) begin
            // keep the offset small so shading is meaningful
            r.hx = r.lx - 32'($signed($urandom_range(0, 1 << 22)) - (1 << 21));
            r.hy = r.ly - 32'($signed($urandom_range(0, 1 << 22)) - (1 << 21));
            r.hz = r.lz - 32'($signed($urandom_range(0, 1 << 22)) - (1 << 21));
            r.nx = unit_comp(); r.ny = unit_comp(); r.nz = unit_comp();
        end else begin
            r.hx = $urandom; r.hy = $urandom; r.hz = $urandom;
            r.nx = $urandom; r.ny = $urandom; r.nz = $urandom;
        end
        if (mode == 9) {r.hx, r.hy, r.hz} = {r.lx, r.ly, r.lz};
        r.lc = {$urandom, $urandom};
        r.sc = {$urandom, $urandom};
        if (mode < 3) begin
            r.lc = {16'($urandom_range(0, 511)), 16'($urandom_range(0, 511)),
                    16'($urandom_range(0, 511))};
            r.sc = {16'($urandom_range(0, 256)), 16'($urandom_range(0, 256)),
                    16'($urandom_range(0, 256))};
        end
        return r;
    endfunction

    initial begin
        ray_t r;
        ray_t dir[$];
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        // light on the point
        r = '{0, 0, 0, 0, 0, 0, 16'h4000, 0, 0, 48'h0100_0100_0100, 48'h0100_0100_0100};
        dir.push_back(r);
        // straight overhead, white on white
        r.lz = 32'h0001_0000; r.nz = 16'h4000; r.nx = 0;
        dir.push_back(r);
        // back facing
        r.nz = 16'hC000; dir.push_back(r);
        // grazing: normal perpendicular
        r.nz = 0; r.nx = 16'h4000; dir.push_back(r);
        // tiny cosine
        r.nx = 0; r.nz = 16'h0001; dir.push_back(r);
        // non-unit normal, max colours, saturate
        r.nz = 16'h7FFF; r.lc = '1; r.sc = '1; dir.push_back(r);
        // most negative normal components
        r.nx = 16'h8000; r.ny = 16'h8000; r.nz = 16'h8000; dir.push_back(r);
        // extreme positions both ways
        r = '{32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000,
              32'h8000_0000, 16'h24F3, 16'h24F3, 16'h24F3, '1, 48'h0100_0100_0100};
        dir.push_back(r);
        r = '{32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
              32'h7FFF_FFFF, 16'hDB0D, 16'hDB0D, 16'hDB0D, 48'h00FF_0080_FFFF, '1};
        dir.push_back(r);
        // one-lsb offset, zero colour
        r = '{1, 0, 0, 0, 0, 0, 16'h4000, 0, 0, 0, 48'h0100_0100_0100};
        dir.push_back(r);
        foreach (dir[i]) send_ray(dir[i], 0);

        for (int k = 0; k < 1700; k++) begin
            if (k == 400) hold_long = 1;
            if (k == 900) begin
                i_valid <= 0;
                wait (board.pending.size() == 0);
                @(posedge i_clk);
            end
            send_ray(random_ray(), (k % 200 < 40) ? 0 : $urandom_range(0, 7));
        end
        i_valid <= 0;
        wait (board.pending.size() == 0);
        repeat (40) @(posedge i_clk);
        if (errors == 0) $display("PASS lambert_diffuse_shade_unit");
        else $display("FAIL lambert_diffuse_shade_unit");
        $finish;
    end

endmodule
